// ----- hdl/dq_pkg.sv -----
// Package for the bounded deque: opcodes, controller states, fixed widths
// and the command and status bundles between controller and datapath.
// No dependencies.
package dq_pkg;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;
  localparam int CNT_MAX = (1 << CNT_W) - 1;

  // Capacity after reset
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 5'd16;

  // Front and rear value shown while the deque is empty
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;   // apply the accepted operation, write the ring
    logic fetch;  // read front and rear entries
    logic load;   // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register empty or being drained this cycle
  } stat_t;

endpackage

// ----- hdl/dq_req_if.sv -----
// Request channel of the bounded deque: one operation per transfer.
// Depends on dq_pkg for field widths.
interface dq_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic signed [dq_pkg::DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ----- hdl/dq_rsp_if.sv -----
// Response channel of the bounded deque: one status result per transfer.
// Depends on dq_pkg for field widths.
interface dq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic signed [dq_pkg::DATA_W-1:0] front_value;
  logic signed [dq_pkg::DATA_W-1:0] rear_value;
  logic [dq_pkg::CNT_W-1:0]        count;
  logic                            is_empty;
  logic                            is_full;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input count, input is_empty, input is_full, output ready);
endinterface

// ----- hdl/bounded_double_ended_queue.sv -----
// Top level of the bounded deque: controller plus datapath with ring memory.
// Depends on dq_pkg, dq_req_if, dq_rsp_if, dq_ctrl and dq_dp.
//
// Channel | Direction | Carries
// --------+-----------+------------------------------------------------------
// req     | in        | opcode, value (one operation per transfer)
// rsp     | out       | ok, front_value, rear_value, count, is_empty, is_full
// cfg     | in        | cfg_we, cfg_data (capacity, no read-back)
//
// An operation runs as accept and ring write, then a registered read of the
// front and rear slots on the single ring memory, then result load.
// A result waits in its own register; the next request is taken once it has
// been loaded, and a held result stalls only the load step.
// Reset (rst, synchronous) empties the deque and sets capacity to 16; ring
// contents are not cleared, as only live slots are ever read.
module bounded_double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [dq_pkg::CNT_W-1:0]  cfg_data,
  dq_req_if.sink                    req,
  dq_rsp_if.source                  rsp
);

  dq_pkg::cmd_t  cmd;
  dq_pkg::stat_t stat;

  // Sequence each operation
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Ring, indices and result register
  dq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .req_opcode      (req.opcode),
    .req_value       (req.value),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_ok          (rsp.ok),
    .rsp_front_value (rsp.front_value),
    .rsp_rear_value  (rsp.rear_value),
    .rsp_count       (rsp.count),
    .rsp_is_empty    (rsp.is_empty),
    .rsp_is_full     (rsp.is_full)
  );

endmodule

// ----- hdl/dq_ctrl.sv -----
// Controller of the bounded deque: sequences accept, fetch and load.
// Depends on dq_pkg for the state type and the command and status bundles.
module dq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dq_pkg::stat_t stat,
  output dq_pkg::cmd_t  cmd
);

  dq_pkg::state_t state;
  dq_pkg::state_t state_next;

  // Hold or advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dq_pkg::ST_IDLE: begin
        if (req_valid) state_next = dq_pkg::ST_FETCH;
      end
      dq_pkg::ST_FETCH: begin
        state_next = dq_pkg::ST_LOAD;
      end
      dq_pkg::ST_LOAD: begin
        if (stat.out_free) state_next = dq_pkg::ST_IDLE;
      end
      default: begin
        state_next = dq_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    unique case (state)
      dq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.exec  = req_valid;
      end
      dq_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      dq_pkg::ST_LOAD: begin
        cmd.load = stat.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/dq_dp.sv -----
// Datapath of the bounded deque: ring memory, head index, fill count,
// capacity register and result register. Depends on dq_pkg.
module dq_dp #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dq_pkg::cmd_t                     cmd,
  output dq_pkg::stat_t                    stat,
  input  logic                             cfg_we,
  input  logic [dq_pkg::CNT_W-1:0]         cfg_data,
  input  logic [1:0]                       req_opcode,
  input  logic signed [dq_pkg::DATA_W-1:0] req_value,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output logic                             rsp_ok,
  output logic signed [dq_pkg::DATA_W-1:0] rsp_front_value,
  output logic signed [dq_pkg::DATA_W-1:0] rsp_rear_value,
  output logic [dq_pkg::CNT_W-1:0]         rsp_count,
  output logic                             rsp_is_empty,
  output logic                             rsp_is_full
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = ((ADDR_W > dq_pkg::CNT_W) ? ADDR_W : dq_pkg::CNT_W) + 1;
  localparam int DEPTH_CLIP = (DEPTH > dq_pkg::CNT_MAX) ? dq_pkg::CNT_MAX : DEPTH;
  localparam logic [dq_pkg::CNT_W-1:0]  CAP_LIMIT = dq_pkg::CNT_W'(DEPTH_CLIP);
  localparam logic [ADDR_W-1:0]         LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0]          DEPTH_SUM = SUM_W'(DEPTH);

  logic [dq_pkg::DATA_W-1:0] ring [DEPTH];

  logic [ADDR_W-1:0]        head;
  logic [ADDR_W-1:0]        head_next;
  logic [dq_pkg::CNT_W-1:0] fill;
  logic [dq_pkg::CNT_W-1:0] fill_next;
  logic [dq_pkg::CNT_W-1:0] capacity;
  logic                     ok;
  logic                     ok_next;
  logic [dq_pkg::DATA_W-1:0] front_data;
  logic [dq_pkg::DATA_W-1:0] rear_data;
  logic                     out_valid;

  logic [dq_pkg::CNT_W-1:0] eff_cap;
  logic                     full;
  logic                     empty;
  logic [ADDR_W-1:0]        head_dec;
  logic [ADDR_W-1:0]        head_inc;
  logic [SUM_W-1:0]         back_sum;
  logic [ADDR_W-1:0]        back_addr;
  logic [SUM_W-1:0]         rear_sum;
  logic [ADDR_W-1:0]        rear_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  dq_pkg::opcode_t          op;

  // Status of the current contents
  always_comb begin
    eff_cap = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
    full    = fill >= eff_cap;
    empty   = fill == '0;
  end

  // Ring positions: one step either way, slot past the rear, rear slot
  always_comb begin
    head_dec  = (head == '0) ? LAST_ADDR : head - ADDR_W'(1);
    head_inc  = (head == LAST_ADDR) ? '0 : head + ADDR_W'(1);
    back_sum  = SUM_W'(head) + SUM_W'(fill);
    back_addr = (back_sum >= DEPTH_SUM) ? ADDR_W'(back_sum - DEPTH_SUM)
                                        : ADDR_W'(back_sum);
    rear_sum  = back_sum - SUM_W'(1);
    if (empty) begin
      rear_addr = head;
    end else if (rear_sum >= DEPTH_SUM) begin
      rear_addr = ADDR_W'(rear_sum - DEPTH_SUM);
    end else begin
      rear_addr = ADDR_W'(rear_sum);
    end
  end

  // Decode the operation; a refused one leaves everything as is
  always_comb begin
    op        = dq_pkg::opcode_t'(req_opcode);
    head_next = head;
    fill_next = fill;
    ok_next   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = back_addr;
    unique case (op)
      dq_pkg::OP_PUSH_FRONT: begin
        wr_addr = head_dec;
        if (!full) begin
          wr_en     = 1'b1;
          head_next = head_dec;
          fill_next = fill + dq_pkg::CNT_W'(1);
          ok_next   = 1'b1;
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (!full) begin
          wr_en     = 1'b1;
          fill_next = fill + dq_pkg::CNT_W'(1);
          ok_next   = 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (!empty) begin
          head_next = head_inc;
          fill_next = fill - dq_pkg::CNT_W'(1);
          ok_next   = 1'b1;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (!empty) begin
          fill_next = fill - dq_pkg::CNT_W'(1);
          ok_next   = 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Advance head and count, take capacity writes
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      fill     <= '0;
      capacity <= dq_pkg::CAPACITY_RESET;
    end else begin
      if (cmd.exec) begin
        head <= head_next;
        fill <= fill_next;
      end
      if (cfg_we) capacity <= cfg_data;
    end
  end

  // Hold the success flag of the operation in flight
  always_ff @(posedge clk) begin
    if (cmd.exec) ok <= ok_next;
  end

  // Write the pushed value
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) ring[wr_addr] <= req_value;
  end

  // Read front and rear entries
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      front_data <= ring[head];
      rear_data  <= ring[rear_addr];
    end
  end

  // Result register valid flag: set on load, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp_ok          <= ok;
      rsp_front_value <= empty ? dq_pkg::EMPTY_VALUE : front_data;
      rsp_rear_value  <= empty ? dq_pkg::EMPTY_VALUE : rear_data;
      rsp_count       <= fill;
      rsp_is_empty    <= empty;
      rsp_is_full     <= full;
    end
  end

  assign rsp_valid     = out_valid;
  assign stat.out_free = !out_valid || rsp_ready;

endmodule
